>>> design/isp_pkg.sv
// Package for the implicant subsumption pruner.
// Holds shared widths, the digit vector type, the engine state type and the
// subsumption test. No dependencies.
package isp_pkg;

  localparam int LEVEL_REGS = 6;
  localparam int LEVEL_W    = 4;
  localparam int COUNT_W    = 3;
  localparam int IN_ROW_W   = 25;
  localparam int TDATA_W    = 32;

  localparam logic [COUNT_W-1:0] REG_COND_COUNT = 3'd0;
  localparam logic [COUNT_W-1:0] REG_LEVELS_0   = 3'd1;
  localparam logic [COUNT_W-1:0] REG_LEVELS_5   = 3'd6;

  typedef logic [LEVEL_REGS-1:0][LEVEL_W-1:0] digits_t;

  typedef struct packed {
    logic [COUNT_W-1:0] used;    // condition count clipped to the supported maximum
    digits_t            levels;
  } isp_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RS_RD,
    S_RS_START,
    S_RS_WAIT,
    S_C_START,
    S_C_WAIT,
    S_CMP_RD,
    S_CMP_CHK,
    S_DECIDE,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_HOLD
  } eng_state_t;

  // True when the kept digits cover the candidate: some used kept digit is a
  // don't care and every other used kept digit matches.
  function automatic logic subsumes(digits_t kept, digits_t cand,
                                    logic [COUNT_W-1:0] used);
    logic has_zero;
    logic all_match;
    has_zero  = 1'b0;
    all_match = 1'b1;
    for (int i = 0; i < LEVEL_REGS; i++) begin
      if (COUNT_W'(i) < used) begin
        if (kept[i] == '0) begin
          has_zero = 1'b1;
        end else if (kept[i] != cand[i]) begin
          all_match = 1'b0;
        end
      end
    end
    return has_zero && all_match;
  endfunction

endpackage

>>> design/implicant_subsumption_pruner_top.sv
// Implicant subsumption pruner, top level. Uses isp_pkg, isp_front, isp_queue, isp_engine.
// A row passes the front register and the queue to the engine, which splits it with the
// bit-serial splitter and walks the kept store; it takes the next row only when done with
// the last. The last row plays the kept list out; after a config write the next row
// re-splits the store first. Sync reset empties list and queue; store not cleared.
module implicant_subsumption_pruner_top
  import isp_pkg::*;
#(
  parameter int MAX_ROWS       = 64,
  parameter int MAX_CONDITIONS = 6,
  parameter int ROW_BITS       = 24
) (
  input  logic                clk,
  input  logic                rst,
  // config write port
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_index,
  input  logic [LEVEL_W-1:0]  cfg_data,
  // input requests
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TDATA_W-1:0]  s_axis_tdata,   // [24:0] row_number, rest zero
  input  logic                s_axis_tlast,   // is_last
  // result requests
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TDATA_W-1:0]  m_axis_tdata,   // [24:0] kept_row, rest zero
  output logic                m_axis_tlast,   // last_kept
  output logic                m_axis_tuser    // [0] overflowed
);

  logic [COUNT_W-1:0]  cond_count;
  digits_t             levels;
  isp_cfg_t            cfg;

  logic                f_valid;
  logic                f_ready;
  logic [ROW_BITS-1:0] f_value;
  logic                f_last;
  logic                q_valid;
  logic                q_ready;
  logic [ROW_BITS:0]   q_data;
  logic [IN_ROW_W-1:0] out_row;

  // Hold the configuration registers; indexes past the supported
  // conditions are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cond_count <= COUNT_W'(3);
      levels     <= {LEVEL_REGS{LEVEL_W'(2)}};
    end else if (cfg_we) begin
      if (cfg_index == REG_COND_COUNT) begin
        cond_count <= cfg_data[COUNT_W-1:0];
      end else if (cfg_index >= REG_LEVELS_0 && cfg_index <= REG_LEVELS_5 &&
                   (cfg_index - REG_LEVELS_0) < COUNT_W'(MAX_CONDITIONS)) begin
        levels[cfg_index - REG_LEVELS_0] <= cfg_data;
      end
    end
  end

  // Clip the condition count to what the design supports.
  always_comb begin
    cfg.levels = levels;
    cfg.used   = (cond_count > COUNT_W'(MAX_CONDITIONS)) ? COUNT_W'(MAX_CONDITIONS)
                                                         : cond_count;
  end

  isp_front #(.ROW_BITS(ROW_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_row     (s_axis_tdata[IN_ROW_W-1:0]),
    .in_last    (s_axis_tlast),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item_value (f_value),
    .item_last  (f_last)
  );

  isp_queue #(.WIDTH(ROW_BITS + 1)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_last, f_value}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  isp_engine #(.MAX_ROWS(MAX_ROWS), .ROW_BITS(ROW_BITS)) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cfg_changed (cfg_we),
    .item_valid  (q_valid),
    .item_ready  (q_ready),
    .item_value  (q_data[ROW_BITS-1:0]),
    .item_last   (q_data[ROW_BITS]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_row     (out_row),
    .out_last    (m_axis_tlast),
    .out_ovf     (m_axis_tuser)
  );

  assign m_axis_tdata = TDATA_W'(out_row);

endmodule

>>> design/isp_front.sv
// Input stage of the pruner: takes stream requests, forms the 0-based row
// value and holds it in a register until the queue takes it. Uses isp_pkg.
module isp_front
  import isp_pkg::*;
#(
  parameter int ROW_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [IN_ROW_W-1:0] in_row,
  input  logic                in_last,
  output logic                item_valid,
  input  logic                item_ready,
  output logic [ROW_BITS-1:0] item_value,
  output logic                item_last
);

  logic                hold_valid;
  logic [ROW_BITS-1:0] hold_value;
  logic                hold_last;
  logic [ROW_BITS-1:0] value_next;

  // Row numbers are 1-based; wrap modulo the row width.
  assign value_next = ROW_BITS'({{ROW_BITS{1'b0}}, in_row} - (ROW_BITS + IN_ROW_W)'(1));
  assign in_ready   = !hold_valid || item_ready;
  assign item_valid = hold_valid;
  assign item_value = hold_value;
  assign item_last  = hold_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_value <= value_next;
      hold_last  <= in_last;
    end
  end

endmodule

>>> design/isp_queue.sv
// Two-entry queue between the input stage and the engine.
// Depends only on its parameter; uses isp_pkg for nothing beyond style.
module isp_queue
  import isp_pkg::*;
#(
  parameter int WIDTH = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [1:0][WIDTH-1:0] slots;
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            fill;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) fill <= fill + 2'd1;
      else if (do_pop && !do_push) fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

>>> design/isp_split.sv
// Mixed-radix digit splitter: restoring division by each condition base,
// one quotient bit per cycle, least significant digit first. Uses isp_pkg.
module isp_split
  import isp_pkg::*;
#(
  parameter int ROW_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ROW_BITS-1:0] value,
  input  isp_cfg_t            cfg,
  output logic                busy,
  output logic                done,
  output digits_t             digits
);

  localparam int BC_W = (ROW_BITS > 1) ? $clog2(ROW_BITS) : 1;

  logic [ROW_BITS-1:0] cur;
  logic [LEVEL_W-1:0]  rem;
  logic [BC_W-1:0]     bitcnt;
  logic [COUNT_W-1:0]  dig_idx;
  logic [LEVEL_W:0]    base;
  logic [LEVEL_W:0]    trial;
  logic                qbit;
  logic [LEVEL_W:0]    rem_new;

  assign base    = {1'b0, cfg.levels[dig_idx]} + (LEVEL_W + 1)'(1);
  assign trial   = {rem, cur[ROW_BITS-1]};
  assign qbit    = (trial >= base);
  assign rem_new = qbit ? (trial - base) : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        if (cfg.used == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && bitcnt == BC_W'(ROW_BITS - 1) && dig_idx == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cur     <= value;
      rem     <= '0;
      bitcnt  <= '0;
      dig_idx <= cfg.used - COUNT_W'(1);
      digits  <= '0;
    end else if (busy) begin
      cur <= {cur[ROW_BITS-2:0], qbit};
      if (bitcnt == BC_W'(ROW_BITS - 1)) begin
        digits[dig_idx] <= rem_new[LEVEL_W-1:0];
        rem             <= '0;
        bitcnt          <= '0;
        dig_idx         <= dig_idx - COUNT_W'(1);
      end else begin
        rem    <= rem_new[LEVEL_W-1:0];
        bitcnt <= bitcnt + BC_W'(1);
      end
    end
  end

endmodule

>>> design/isp_engine.sv
// Back end of the pruner: splits each row into digits, compares it with the
// kept store, stores survivors and plays the list out. Uses isp_pkg, isp_split.
module isp_engine
  import isp_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int ROW_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  isp_cfg_t            cfg,
  input  logic                cfg_changed,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [ROW_BITS-1:0] item_value,
  input  logic                item_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IN_ROW_W-1:0] out_row,
  output logic                out_last,
  output logic                out_ovf
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);

  eng_state_t state, state_next;

  logic [ROW_BITS-1:0] mem_val [MAX_ROWS];
  digits_t             mem_dig [MAX_ROWS];
  logic [ROW_BITS-1:0] rd_val;
  digits_t             rd_dig;

  logic [ROW_BITS-1:0] cand_v;
  logic                cand_last;
  digits_t             cand_dig;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       kept_count;
  logic                ovf;
  logic                stale;
  logic                dropped;

  logic                mem_rd;
  logic                split_start;
  logic [ROW_BITS-1:0] split_value;
  logic                split_busy;
  logic                split_done;
  digits_t             split_digits;
  logic                at_end;
  logic                hit;
  logic [ROW_BITS:0]   row_plus;

  assign at_end   = (idx == kept_count);
  assign hit      = subsumes(rd_dig, cand_dig, cfg.used);
  assign row_plus = {1'b0, rd_val} + (ROW_BITS + 1)'(1);

  isp_split #(.ROW_BITS(ROW_BITS)) u_split (
    .clk    (clk),
    .rst    (rst),
    .start  (split_start),
    .value  (split_value),
    .cfg    (cfg),
    .busy   (split_busy),
    .done   (split_done),
    .digits (split_digits)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (item_valid) state_next = (stale && kept_count != '0) ? S_RS_RD
                                                                          : S_C_START;
      S_RS_RD:     state_next = at_end ? S_C_START : S_RS_START;
      S_RS_START:  state_next = S_RS_WAIT;
      S_RS_WAIT:   if (split_done) state_next = S_RS_RD;
      S_C_START:   state_next = S_C_WAIT;
      S_C_WAIT:    if (split_done) state_next = S_CMP_RD;
      S_CMP_RD:    state_next = at_end ? S_DECIDE : S_CMP_CHK;
      S_CMP_CHK:   state_next = hit ? S_DECIDE : S_CMP_RD;
      S_DECIDE:    state_next = cand_last ? S_EMIT_RD : S_IDLE;
      S_EMIT_RD:   state_next = at_end ? S_IDLE : S_EMIT_LD;
      S_EMIT_LD:   state_next = S_EMIT_HOLD;
      S_EMIT_HOLD: if (out_ready) state_next = S_EMIT_RD;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_ready  = (state == S_IDLE);
    mem_rd      = ((state == S_RS_RD) || (state == S_CMP_RD) || (state == S_EMIT_RD))
                  && !at_end;
    split_start = (state == S_RS_START) || (state == S_C_START);
    split_value = (state == S_RS_START) ? rd_val : cand_v;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Kept store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_val <= mem_val[idx[AW-1:0]];
      rd_dig <= mem_dig[idx[AW-1:0]];
    end
    if (state == S_RS_WAIT && split_done) begin
      mem_dig[idx[AW-1:0]] <= split_digits;
    end
    if (state == S_DECIDE && !dropped && kept_count < CW'(MAX_ROWS)) begin
      mem_val[kept_count[AW-1:0]] <= cand_v;
      mem_dig[kept_count[AW-1:0]] <= cand_dig;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      ovf        <= 1'b0;
      stale      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_changed) stale <= 1'b1;
      else if (state == S_RS_RD && at_end) stale <= 1'b0;
      if (state == S_DECIDE && !dropped) begin
        if (kept_count < CW'(MAX_ROWS)) kept_count <= kept_count + CW'(1);
        else                            ovf        <= 1'b1;
      end
      if (state == S_EMIT_RD && at_end) begin
        kept_count <= '0;
        ovf        <= 1'b0;
      end
      if (state == S_EMIT_LD)                    out_valid <= 1'b1;
      else if (out_valid && out_ready)           out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cand_v    <= item_value;
        cand_last <= item_last;
        idx       <= '0;
        dropped   <= 1'b0;
      end
      S_RS_RD:   if (at_end) idx <= '0;
      S_RS_WAIT: if (split_done) idx <= idx + CW'(1);
      S_C_WAIT:  if (split_done) cand_dig <= split_digits;
      S_CMP_CHK: begin
        if (hit) dropped <= 1'b1;
        else     idx     <= idx + CW'(1);
      end
      S_DECIDE:  idx <= '0;
      S_EMIT_LD: begin
        out_row  <= IN_ROW_W'(row_plus);
        out_last <= (idx + CW'(1) == kept_count);
        out_ovf  <= ovf;
      end
      S_EMIT_HOLD: if (out_ready) idx <= idx + CW'(1);
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CW'(MAX_ROWS))
    else $error("kept count above store size");

  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_EMIT_HOLD || state == S_EMIT_RD)
    else $error("result shown outside playback");

  a_split_idle: assert property (@(posedge clk) disable iff (rst)
    split_start |-> !split_busy)
    else $error("splitter started while busy");

  a_list_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD && at_end) |=> kept_count == '0 && !ovf)
    else $error("list state not cleared after playback");

endmodule
